// ===== src/pab_pkg.sv =====
// Shared types and constants for the phase accumulator bank.
package pab_pkg;

    localparam int CH_W       = 4;
    localparam int PHASE_W    = 14;
    localparam int FREQ_W     = 16;
    localparam int STEP_SHIFT = 2;

    typedef enum logic {
        MODE_TICK  = 1'b0,
        MODE_WRITE = 1'b1
    } t_mode;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef struct packed {
        logic issue;
        logic last;
    } t_seq_ctl;

    typedef struct packed {
        logic [CH_W-1:0]    out_channel;
        logic [PHASE_W-1:0] phase;
        logic               last;
    } t_result;

endpackage

// ===== src/pab_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module pab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/pab_seq.sv =====
// Channel sequencer: walks every channel once per tick, one read issue per cycle while i_can_issue is high.
module pab_seq #(
    parameter int CHANNELS = 16,
    parameter int IDX_W    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_can_issue,
    output logic              o_busy,
    output pab_pkg::t_seq_ctl o_ctl,
    output logic [IDX_W-1:0]  o_idx
);

    pab_pkg::t_seq_state r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                is_last;

    assign is_last = (r_idx == IDX_W'(CHANNELS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            pab_pkg::SEQ_IDLE: begin
                if (i_start) n_state = pab_pkg::SEQ_RUN;
            end
            pab_pkg::SEQ_RUN: begin
                if (i_can_issue && is_last) n_state = pab_pkg::SEQ_IDLE;
            end
            default: n_state = pab_pkg::SEQ_IDLE;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        if (r_state == pab_pkg::SEQ_IDLE) begin
            n_idx = '0;
        end else if (i_can_issue && !is_last) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_comb begin
        o_busy    = (r_state == pab_pkg::SEQ_RUN);
        o_ctl     = '0;
        o_ctl.issue = o_busy && i_can_issue;
        o_ctl.last  = is_last;
        o_idx     = r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pab_pkg::SEQ_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ===== src/pab_outq.sv =====
// Two-entry result queue that decouples the update path from a stalling receiver.
module pab_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pab_pkg::t_result i_data,
    input  logic             i_stall,
    output logic             o_valid,
    output pab_pkg::t_result o_data,
    output logic [1:0]       o_count
);

    pab_pkg::t_result r_buf [2];
    logic             r_wp, r_rp;
    logic [1:0]       r_count;
    logic             pop;

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_buf[r_rp];
    assign o_count = r_count;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (pop)    r_rp <= ~r_rp;
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

endmodule

// ===== src/phase_accumulator_bank.sv =====
// Top level of the phase accumulator bank.
//
// Input channel (i_valid / o_stall): an item with i_mode = 1 writes a frequency
// word for i_channel, clamped to 4*PHASE_MODULUS-1; writes to channels at or
// beyond CHANNELS are dropped. An item with i_mode = 0 is a tick: every phase
// advances by its frequency word divided by four, wrapped modulo PHASE_MODULUS.
// Output channel (o_valid / i_stall): a tick gives CHANNELS items in channel
// order, o_last marking the final channel. A write gives none.
// Phases and frequency words sit in two RAMs with registered reads; the
// sequencer reads one channel per cycle while the result queue has room, and
// writes the new phase back on the following cycle. The first item of a tick
// passes through the sequencer, the RAM read register and the result queue;
// the rest follow one per cycle while i_stall is low. o_stall rises the cycle
// after a tick is taken and stays high until the read of the last channel is
// issued, so no new item is taken during the walk; a write leaves o_stall low.
// When the receiver stalls, a two-entry queue holds results and the walk
// pauses. Reset clears all phases and frequency words to zero through
// per-channel valid bits, with no clearing pass.
module phase_accumulator_bank #(
    parameter int CHANNELS      = 16,
    parameter int PHASE_MODULUS = 10000
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_mode,
    input  logic [pab_pkg::CH_W-1:0]     i_channel,
    input  logic [pab_pkg::FREQ_W-1:0]   i_freq_word,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [pab_pkg::CH_W-1:0]     o_out_channel,
    output logic [pab_pkg::PHASE_W-1:0]  o_phase,
    output logic                         o_last
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [pab_pkg::FREQ_W-1:0] FREQ_LIMIT =
        pab_pkg::FREQ_W'(4 * PHASE_MODULUS - 1);
    localparam logic [pab_pkg::PHASE_W:0] MODULUS = (pab_pkg::PHASE_W + 1)'(PHASE_MODULUS);

    logic                        busy;
    pab_pkg::t_seq_ctl           ctl;
    logic [IDX_W-1:0]            seq_idx;
    logic                        in_acc, tick_acc, wr_acc;
    logic [pab_pkg::FREQ_W-1:0]  freq_clamped;
    logic [CHANNELS-1:0]         r_fvld, r_pvld;
    logic                        r_rd_pend, r_rd_last, r_rd_fvld, r_rd_pvld;
    logic [IDX_W-1:0]            r_rd_idx;
    logic [pab_pkg::FREQ_W-1:0]  freq_rd, freq_eff;
    logic [pab_pkg::PHASE_W-1:0] phase_rd, phase_eff, step, phase_new;
    logic [pab_pkg::PHASE_W:0]   sum;
    pab_pkg::t_result            res, q_data;
    logic [1:0]                  q_count;
    logic [2:0]                  occ;
    logic                        pop, can_issue;

    assign in_acc   = i_valid && !o_stall;
    assign tick_acc = in_acc && (pab_pkg::t_mode'(i_mode) == pab_pkg::MODE_TICK);
    assign wr_acc   = in_acc && (pab_pkg::t_mode'(i_mode) == pab_pkg::MODE_WRITE)
                      && (int'(i_channel) < CHANNELS);
    assign freq_clamped = (i_freq_word > FREQ_LIMIT) ? FREQ_LIMIT : i_freq_word;
    assign o_stall  = busy;

    assign pop       = o_valid && !i_stall;
    assign occ       = {1'b0, q_count} + {2'b0, r_rd_pend};
    assign can_issue = (occ < 3'd2) || ((occ == 3'd2) && pop);

    pab_seq #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (tick_acc),
        .i_can_issue (can_issue),
        .o_busy      (busy),
        .o_ctl       (ctl),
        .o_idx       (seq_idx)
    );

    pab_ram #(
        .WIDTH (pab_pkg::FREQ_W),
        .DEPTH (CHANNELS)
    ) u_freq_ram (
        .i_clk   (i_clk),
        .i_we    (wr_acc),
        .i_waddr (IDX_W'(i_channel)),
        .i_wdata (freq_clamped),
        .i_raddr (seq_idx),
        .o_rdata (freq_rd)
    );

    pab_ram #(
        .WIDTH (pab_pkg::PHASE_W),
        .DEPTH (CHANNELS)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (r_rd_pend),
        .i_waddr (r_rd_idx),
        .i_wdata (phase_new),
        .i_raddr (seq_idx),
        .o_rdata (phase_rd)
    );

    // unwritten entries read as zero
    assign freq_eff  = r_rd_fvld ? freq_rd : '0;
    assign phase_eff = r_rd_pvld ? phase_rd : '0;
    assign step      = pab_pkg::PHASE_W'(freq_eff >> pab_pkg::STEP_SHIFT);
    assign sum       = {1'b0, phase_eff} + {1'b0, step};
    assign phase_new = (sum >= MODULUS) ? pab_pkg::PHASE_W'(sum - MODULUS)
                                        : pab_pkg::PHASE_W'(sum);

    always_comb begin
        res.out_channel = pab_pkg::CH_W'(r_rd_idx);
        res.phase       = phase_new;
        res.last        = r_rd_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_fvld    <= '0;
            r_pvld    <= '0;
        end else begin
            r_rd_pend <= ctl.issue;
            if (wr_acc)    r_fvld[IDX_W'(i_channel)] <= 1'b1;
            if (r_rd_pend) r_pvld[r_rd_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.issue) begin
            r_rd_idx  <= seq_idx;
            r_rd_last <= ctl.last;
            r_rd_fvld <= r_fvld[seq_idx];
            r_rd_pvld <= r_pvld[seq_idx];
        end
    end

    pab_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_rd_pend),
        .i_data  (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_out_channel = q_data.out_channel;
    assign o_phase       = q_data.phase;
    assign o_last        = q_data.last;

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> ((q_count < 2'd2) || pop))
        else $error("result queue overflow");

    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> o_stall)
        else $error("tick taken without starting the walk");

    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (o_out_channel == pab_pkg::CH_W'(CHANNELS - 1)))
        else $error("last mark on wrong channel");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_phase} < MODULUS))
        else $error("phase out of range");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the phase accumulator bank: directed and random writes and ticks.
`timescale 1ns / 1ps

module tb_top;

    localparam int CHANNELS     = 16;
    localparam int PHASE_MOD    = 10000;
    localparam int FREQ_MAX     = 4 * PHASE_MOD - 1;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PRINT_LIMIT  = 40;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_mode;
    logic [pab_pkg::CH_W-1:0]     i_channel;
    logic [pab_pkg::FREQ_W-1:0]   i_freq_word;
    logic                         o_valid;
    logic                         i_stall;
    logic [pab_pkg::CH_W-1:0]     o_out_channel;
    logic [pab_pkg::PHASE_W-1:0]  o_phase;
    logic                         o_last;

    logic [pab_pkg::FREQ_W-1:0]   freq_words [CHANNELS];
    logic [pab_pkg::PHASE_W-1:0]  phases [CHANNELS];
    pab_pkg::t_result             pending_phases [$];

    int  errors      = 0;
    int  cycle_count = 0;
    int  hold_cycles = 0;
    bit  tx_idle_on  = 1'b0;
    bit  rx_idle_on  = 1'b0;

    phase_accumulator_bank #(
        .CHANNELS      (CHANNELS),
        .PHASE_MODULUS (PHASE_MOD)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_channel     (i_channel),
        .i_freq_word   (i_freq_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_phase       (o_phase),
        .o_last        (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
        errors++;
    endtask

    // Bank model
    task automatic store_freq_word(input logic [pab_pkg::CH_W-1:0] ch,
                                   input logic [pab_pkg::FREQ_W-1:0] fw);
        freq_words[ch] = (fw > FREQ_MAX) ? pab_pkg::FREQ_W'(FREQ_MAX) : fw;
    endtask

    task automatic advance_all_phases();
        logic [pab_pkg::PHASE_W:0] sum;
        pab_pkg::t_result          res;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            sum = {1'b0, phases[ch]}
                  + (pab_pkg::PHASE_W+1)'(freq_words[ch] >> pab_pkg::STEP_SHIFT);
            if (sum >= PHASE_MOD)
                sum = (pab_pkg::PHASE_W+1)'(sum - PHASE_MOD);
            phases[ch]      = sum[pab_pkg::PHASE_W-1:0];
            res.out_channel = pab_pkg::CH_W'(ch);
            res.phase       = sum[pab_pkg::PHASE_W-1:0];
            res.last        = (ch == CHANNELS - 1);
            pending_phases.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            if (i_mode == pab_pkg::MODE_WRITE)
                store_freq_word(i_channel, i_freq_word);
            else
                advance_all_phases();
        end
    end

    always @(posedge i_clk) begin : check_phases
        pab_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_phases.size() == 0) begin
                report_mismatch("unexpected result, channel", int'(o_out_channel), -1);
            end else begin
                want = pending_phases.pop_front();
                if (o_out_channel !== want.out_channel)
                    report_mismatch("out_channel", int'(o_out_channel),
                                    int'(want.out_channel));
                if (o_phase !== want.phase)
                    report_mismatch("phase", int'(o_phase), int'(want.phase));
                if (o_last !== want.last)
                    report_mismatch("last", int'(o_last), int'(want.last));
            end
        end
    end

    // Receiver: random stall bursts, or a long hold when asked for
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                while (hold_cycles > 0) begin
                    @(posedge i_clk);
                    hold_cycles--;
                end
                i_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input pab_pkg::t_mode mode, input logic [pab_pkg::CH_W-1:0] ch,
                             input logic [pab_pkg::FREQ_W-1:0] fw);
        i_valid     <= 1'b1;
        i_mode      <= mode;
        i_channel   <= ch;
        i_freq_word <= fw;
        do @(posedge i_clk); while (o_stall);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    task automatic send_tick();
        send_item(pab_pkg::MODE_TICK, pab_pkg::CH_W'($urandom_range(0, 15)),
                  pab_pkg::FREQ_W'($urandom_range(0, 65535)));
    endtask

    function automatic logic [pab_pkg::FREQ_W-1:0] pick_freq_word();
        case ($urandom_range(0, 5))
            0: pick_freq_word = pab_pkg::FREQ_W'($urandom_range(0, 7));
            1: pick_freq_word = pab_pkg::FREQ_W'($urandom_range(FREQ_MAX - 4, FREQ_MAX + 4));
            2: pick_freq_word = pab_pkg::FREQ_W'($urandom_range(FREQ_MAX + 1, 65535));
            default: pick_freq_word = pab_pkg::FREQ_W'($urandom_range(0, FREQ_MAX));
        endcase
    endfunction

    task automatic test_reset_state();
        send_item(pab_pkg::MODE_TICK, '0, '0);
    endtask

    task automatic test_directed();
        send_item(pab_pkg::MODE_WRITE, 4'd0,  16'd39999);
        send_item(pab_pkg::MODE_WRITE, 4'd15, 16'hFFFF);
        send_item(pab_pkg::MODE_WRITE, 4'd1,  16'd40000);
        send_item(pab_pkg::MODE_WRITE, 4'd2,  16'd20000);
        send_item(pab_pkg::MODE_WRITE, 4'd3,  16'd3);
        send_item(pab_pkg::MODE_WRITE, 4'd4,  16'd4);
        send_item(pab_pkg::MODE_WRITE, 4'd5,  16'hAAAA);
        send_item(pab_pkg::MODE_WRITE, 4'd6,  16'h5555);
        send_item(pab_pkg::MODE_WRITE, 4'd7,  16'd39996);
        send_item(pab_pkg::MODE_WRITE, 4'd8,  16'd1);
        send_item(pab_pkg::MODE_WRITE, 4'd10, 16'h7FFF);
        // tick fields are don't-care
        send_item(pab_pkg::MODE_TICK, 4'd15, 16'hFFFF);
        send_item(pab_pkg::MODE_TICK, 4'd10, 16'h5555);
        send_item(pab_pkg::MODE_TICK, 4'd5,  16'hAAAA);
        send_item(pab_pkg::MODE_WRITE, 4'd0, 16'd0);
        send_item(pab_pkg::MODE_WRITE, 4'd15, 16'd0);
        send_item(pab_pkg::MODE_TICK, 4'd0, 16'd0);
        send_item(pab_pkg::MODE_WRITE, 4'd9, 16'd8);
        send_item(pab_pkg::MODE_TICK, 4'd9, 16'd39999);
    endtask

    task automatic test_random(input int n);
        int k;
        k = 0;
        while (k < n) begin
            // zero to three writes, then one or two ticks
            repeat ($urandom_range(0, 3)) begin
                send_item(pab_pkg::MODE_WRITE, pab_pkg::CH_W'($urandom_range(0, 15)),
                          pick_freq_word());
                k++;
            end
            repeat ($urandom_range(1, 2)) begin
                send_tick();
                k++;
            end
            if ($urandom_range(0, 9) == 0) begin
                tx_idle_on = ~tx_idle_on;
                rx_idle_on = ~rx_idle_on;
            end
        end
    endtask

    task automatic test_backpressure();
        tx_idle_on  = 1'b0;
        hold_cycles = 150;
        repeat (4) send_tick();
        send_item(pab_pkg::MODE_WRITE, 4'd11, 16'd12345);
        send_tick();
    endtask

    task automatic test_no_idle(input int n);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (n) begin
            if ($urandom_range(0, 1) == 0)
                send_tick();
            else
                send_item(pab_pkg::MODE_WRITE, pab_pkg::CH_W'($urandom_range(0, 15)),
                          pick_freq_word());
        end
    endtask

    initial begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            freq_words[ch] = '0;
            phases[ch]     = '0;
        end
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_mode      <= pab_pkg::MODE_TICK;
        i_channel   <= '0;
        i_freq_word <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_random(230);
        test_backpressure();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_random(30);
        test_no_idle(30);
        i_valid <= 1'b0;

        while (pending_phases.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0 && pending_phases.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
src/pab_pkg.sv
src/pab_ram.sv
src/pab_seq.sv
src/pab_outq.sv
src/phase_accumulator_bank.sv
sim/tb_top.sv
